### src/npcm_pkg.sv
// Shared types and constants of the nearest palette color mapper.
`default_nettype none

package npcm_pkg;

    localparam int PALETTE_SIZE = 16;
    localparam int IDX_W        = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int CNT_W        = $clog2(PALETTE_SIZE + 1);
    localparam int CFG_W        = 5;
    localparam int DIST_W       = 18;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_MAP  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [3:0] entry_index;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       pixel_last;
    } pixel_t;

    typedef struct packed
    {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [3:0] chosen_index;
        logic       result_last;
    } result_t;

    // Beat handed from one cell to the next: the item plus the running best match.
    typedef struct packed
    {
        pixel_t            item;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  best_idx;
        logic [7:0]        best_red;
        logic [7:0]        best_green;
        logic [7:0]        best_blue;
    } beat_t;

    function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

`default_nettype wire

### src/nearest_palette_color_map.sv
// Top level of the nearest palette color mapper: cell chain and result register.
// A pixel beat passes the PALETTE_SIZE cell registers, then the result register.
// Throughput: one beat (load or pixel) per cycle while the cell chain advances as a
// whole. The chain stalls only while the result register holds a stalled beat.
// Reset clears the valid bits and sets the color count register to 1; palette entries
// stay undefined until loaded. A load beat travels the chain and writes its own cell.
`default_nettype none

module nearest_palette_color_map
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write_en,
    input  wire logic [npcm_pkg::CFG_W-1:0] active_colors,
    input  wire logic                     pixel_valid,
    output logic                          pixel_stall,
    input  wire npcm_pkg::pixel_t         pixel,
    output logic                          result_valid,
    input  wire logic                     result_stall,
    output npcm_pkg::result_t             result
);
    import npcm_pkg::*;

    logic [CFG_W-1:0] count_reg;
    logic [CNT_W-1:0] count_eff;
    logic             advance;

    // Chain taps: entry 0 is the input beat, entry PALETTE_SIZE the tail
    logic             chain_valid [PALETTE_SIZE+1];
    beat_t            chain_beat  [PALETTE_SIZE+1];

    logic             res_valid_reg;
    result_t          res_reg;
    logic             tail_is_pixel;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CFG_W'(1);
        end
        else if (cfg_write_en)
        begin
            count_reg <= active_colors;
        end
    end

    // Clamp the count: zero acts as one, anything above the palette saturates
    always_comb
    begin
        if (count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (32'(count_reg) > PALETTE_SIZE)
        begin
            count_eff = CNT_W'(PALETTE_SIZE);
        end
        else
        begin
            count_eff = CNT_W'(count_reg);
        end
    end

    // Advance the whole chain whenever the result register can take the tail beat
    assign advance     = !res_valid_reg || !result_stall;
    assign pixel_stall = !advance;

    always_comb
    begin
        chain_valid[0]           = pixel_valid;
        chain_beat[0]            = '0;
        chain_beat[0].item       = pixel;
    end

    for (genvar j = 0; j < PALETTE_SIZE; j++)
    begin : g_cell
        npcm_cell u_cell
        (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .cell_id        (IDX_W'(j)),
            .count_eff      (count_eff),
            .beat_in_valid  (chain_valid[j]),
            .beat_in        (chain_beat[j]),
            .beat_out_valid (chain_valid[j+1]),
            .beat_out       (chain_beat[j+1])
        );
    end

    // Drop load beats at the tail; only pixels produce a result
    assign tail_is_pixel = chain_valid[PALETTE_SIZE]
                        && (chain_beat[PALETTE_SIZE].item.op == OP_MAP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= tail_is_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg.out_red      <= chain_beat[PALETTE_SIZE].best_red;
            res_reg.out_green    <= chain_beat[PALETTE_SIZE].best_green;
            res_reg.out_blue     <= chain_beat[PALETTE_SIZE].best_blue;
            res_reg.chosen_index <= 4'(chain_beat[PALETTE_SIZE].best_idx);
            res_reg.result_last  <= chain_beat[PALETTE_SIZE].item.pixel_last;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A load beat leaving the chain never turns into a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && chain_valid[PALETTE_SIZE]
         && (chain_beat[PALETTE_SIZE].item.op == OP_LOAD)) |=> !result_valid)
        else $error("load beat produced a result");

    // A pixel leaving the chain shows as a result with its own last flag
    a_pixel_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && tail_is_pixel) |=>
        (result_valid && (result.result_last == $past(chain_beat[PALETTE_SIZE].item.pixel_last))))
        else $error("pixel beat lost at the chain tail");

    // The chosen entry lies within the searched count
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (32'(result.chosen_index) < 32'(count_eff)))
        else $error("chosen index outside active colors");

    // A held chain keeps its tail beat
    a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(chain_valid[PALETTE_SIZE]) && $stable(chain_beat[PALETTE_SIZE])))
        else $error("chain tail changed while stalled");

endmodule

`default_nettype wire

### src/npcm_cell.sv
// One palette cell: holds one entry, compares the passing pixel, forwards the beat.
`default_nettype none

module npcm_cell
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     advance,
    input  wire logic [npcm_pkg::IDX_W-1:0] cell_id,
    input  wire logic [npcm_pkg::CNT_W-1:0] count_eff,
    input  wire logic                     beat_in_valid,
    input  wire npcm_pkg::beat_t          beat_in,
    output logic                          beat_out_valid,
    output npcm_pkg::beat_t               beat_out
);
    import npcm_pkg::*;

    logic [23:0]       pal_reg;
    logic              valid_reg;
    beat_t             beat_reg;
    beat_t             beat_next;
    logic [DIST_W-1:0] cand_dist;
    logic              active;
    logic              load_hit;

    assign cand_dist = DIST_W'(sq_diff(beat_in.item.in_red,   pal_reg[23:16]))
                     + DIST_W'(sq_diff(beat_in.item.in_green, pal_reg[15:8]))
                     + DIST_W'(sq_diff(beat_in.item.in_blue,  pal_reg[7:0]));

    assign active   = (CNT_W'(cell_id) < count_eff) || (cell_id == '0);
    assign load_hit = beat_in_valid && (beat_in.item.op == OP_LOAD)
                   && (32'(beat_in.item.entry_index) == 32'(cell_id));

    always_comb
    begin
        beat_next = beat_in;
        // Take over the best match; the first cell always seeds it
        if (beat_in_valid && (beat_in.item.op == OP_MAP) && active
            && ((cell_id == '0) || (cand_dist < beat_in.best_dist)))
        begin
            beat_next.best_dist  = cand_dist;
            beat_next.best_idx   = cell_id;
            beat_next.best_red   = pal_reg[23:16];
            beat_next.best_green = pal_reg[15:8];
            beat_next.best_blue  = pal_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= beat_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg <= beat_next;
            if (load_hit)
            begin
                pal_reg <= {beat_in.item.in_red, beat_in.item.in_green, beat_in.item.in_blue};
            end
        end
    end

    assign beat_out_valid = valid_reg;
    assign beat_out       = beat_reg;

endmodule

`default_nettype wire
